FILE: rtl/ambient_lux_settle_qualifier_macros.svh
// ----------------------------------------------------------------------------
// Ambient lux settle qualifier assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AMBIENT_LUX_SETTLE_QUALIFIER_MACROS_SVH
`define AMBIENT_LUX_SETTLE_QUALIFIER_MACROS_SVH

// same-cycle implication
`define ALSQ_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alsq: same-cycle check failed");

// next-cycle implication
`define ALSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alsq: next-cycle check failed");

`endif

FILE: rtl/alsq_pkg.sv
// ----------------------------------------------------------------------------
// Ambient lux settle qualifier package
// Widths, request and register codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package alsq_pkg;

  localparam int LUX_W   = 24;
  localparam int CNT_W   = 8;
  localparam int FRAC_W  = 8;
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 2;
  localparam int ACC_W   = LUX_W + FRAC_W;
  localparam int STEP_W  = $clog2(FRAC_W);
  localparam int IN_W    = ((LUX_W + 7) / 8) * 8;
  localparam int OUT_W   = ((LUX_W + 2 + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - LUX_W - 2;

  localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic [STEP_W-1:0] STEP_LAST  = STEP_W'(FRAC_W - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [LUX_W-1:0]  WHOLE_MASK = ~LUX_W'(15);

  localparam logic [FRAC_W-1:0] DRAMATIC_RST   = FRAC_W'(154);
  localparam logic [FRAC_W-1:0] JITTER_RST     = FRAC_W'(51);
  localparam logic [FRAC_W-1:0] WEIGHT_RST     = FRAC_W'(26);
  localparam logic [CNT_W-1:0]  STEADY_RST     = CNT_W'(10);
  localparam logic [LUX_W-1:0]  USER_POINT_RST = LUX_W'(16);

  typedef enum logic [REQ_W-1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_OVERRIDE = 2'd1,
    REQ_HOLD_END = 2'd2,
    REQ_USER_PT  = 2'd3
  } req_t;

  typedef enum logic [IDX_W-1:0] {
    REG_DRAMATIC = 2'd0,
    REG_JITTER   = 2'd1,
    REG_WEIGHT   = 2'd2,
    REG_STEADY   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAM_MUL,
    ST_DRAM_CMP,
    ST_FILT_MUL,
    ST_FILT_END,
    ST_JIT_MUL,
    ST_JIT_CMP,
    ST_WB
  } state_t;

  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  // |a - ref| * 2^FRAC_W > ref * frac, with the product already formed
  function automatic logic beyond(input logic [LUX_W-1:0] a,
                                  input logic [LUX_W-1:0] ref_lux,
                                  input logic [ACC_W-1:0] prod);
    logic [LUX_W-1:0] d;
    d = (a >= ref_lux) ? (a - ref_lux) : (ref_lux - a);
    return {d, {FRAC_W{1'b0}}} > prod;
  endfunction

endpackage

FILE: rtl/ambient_lux_settle_qualifier.sv
// ----------------------------------------------------------------------------
// Ambient lux settle qualifier
// Qualifies ambient lux samples and commits a new backlight lux when the
// light has settled or changed dramatically; handles override and user point.
//
//   channel  dir  payload
//   s_*      in   tuser: req_type[1:0]; tdata: lux_value[23:0]
//   m_*      out  tdata: commit_valid, commit_lux[23:0], auto_running, zero pad
//   cfg_*    in   write enable, index 0..3, 8-bit data
//
// Control requests skip to write-back. A sample forms the dramatic product and
// compares; unless paused or dramatic, the filter path then forms the filter
// update and jitter check, all on one shift-add unit, one multiplier bit a cycle.
// Synchronous reset restores all but the datapath; no clearing pass is needed.
// A new request is taken only in idle; a held result stalls the sequencer
// in write-back until m_tready frees the output register.
// ----------------------------------------------------------------------------
`include "ambient_lux_settle_qualifier_macros.svh"

module ambient_lux_settle_qualifier (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [alsq_pkg::IN_W-1:0]    s_tdata,   // lux_value
  input  logic [alsq_pkg::REQ_W-1:0]   s_tuser,   // req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [alsq_pkg::OUT_W-1:0]   m_tdata,   // commit_valid, commit_lux, auto_running
  input  logic                         cfg_we,
  input  logic [alsq_pkg::IDX_W-1:0]   cfg_index,
  input  logic [alsq_pkg::FRAC_W-1:0]  cfg_data
);

  alsq_pkg::state_t state, state_next;

  logic [alsq_pkg::FRAC_W-1:0] dramatic_frac, jitter_frac, filter_weight;
  logic [alsq_pkg::CNT_W-1:0]  steady_needed;

  logic [alsq_pkg::LUX_W-1:0]  last_sample, filtered_lux, set_lux, held_lux, user_point;
  logic [alsq_pkg::CNT_W-1:0]  steady_run, dramatic_run;
  logic                        running, hold_active;

  logic [alsq_pkg::LUX_W-1:0]  lux_r, ref_r, res_lux;
  logic                        res_commit;

  logic [alsq_pkg::ACC_W-1:0]  acc, mcand;
  logic [alsq_pkg::FRAC_W-1:0] mplier;
  logic [alsq_pkg::STEP_W-1:0] step;

  logic                        accept, mul_last, out_free, far;
  logic [alsq_pkg::LUX_W-1:0]  in_lux, filt_new;
  logic [alsq_pkg::LUX_W:0]    filt_diff;
  logic [alsq_pkg::CNT_W-1:0]  cnt_inc;
  alsq_pkg::req_t              in_req;

  assign in_lux    = s_tdata[alsq_pkg::LUX_W-1:0];
  assign in_req    = alsq_pkg::req_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;
  assign mul_last  = (step == alsq_pkg::STEP_LAST);
  assign out_free  = !m_tvalid || m_tready;
  assign far       = alsq_pkg::beyond(lux_r, ref_r, acc);
  assign filt_new  = acc[alsq_pkg::ACC_W-1:alsq_pkg::FRAC_W];
  assign filt_diff = {1'b0, lux_r} - {1'b0, filtered_lux};
  assign cnt_inc   = (state == alsq_pkg::ST_DRAM_CMP) ? alsq_pkg::count_up(dramatic_run)
                                                       : alsq_pkg::count_up(steady_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= alsq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    case (state)
      alsq_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (in_req == alsq_pkg::REQ_SAMPLE) ? alsq_pkg::ST_DRAM_MUL
                                                        : alsq_pkg::ST_WB;
        end
      end
      alsq_pkg::ST_DRAM_MUL: if (mul_last) state_next = alsq_pkg::ST_DRAM_CMP;
      alsq_pkg::ST_DRAM_CMP: begin
        state_next = (running && !far) ? alsq_pkg::ST_FILT_MUL : alsq_pkg::ST_WB;
      end
      alsq_pkg::ST_FILT_MUL: if (mul_last) state_next = alsq_pkg::ST_FILT_END;
      alsq_pkg::ST_FILT_END: state_next = alsq_pkg::ST_JIT_MUL;
      alsq_pkg::ST_JIT_MUL:  if (mul_last) state_next = alsq_pkg::ST_JIT_CMP;
      alsq_pkg::ST_JIT_CMP:  state_next = alsq_pkg::ST_WB;
      alsq_pkg::ST_WB:       if (out_free) state_next = alsq_pkg::ST_IDLE;
      default:               state_next = alsq_pkg::ST_IDLE;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dramatic_frac <= alsq_pkg::DRAMATIC_RST;
      jitter_frac   <= alsq_pkg::JITTER_RST;
      filter_weight <= alsq_pkg::WEIGHT_RST;
      steady_needed <= alsq_pkg::STEADY_RST;
    end else if (cfg_we) begin
      case (alsq_pkg::reg_idx_t'(cfg_index))
        alsq_pkg::REG_DRAMATIC: dramatic_frac <= cfg_data;
        alsq_pkg::REG_JITTER:   jitter_frac   <= cfg_data;
        alsq_pkg::REG_WEIGHT:   filter_weight <= cfg_data;
        alsq_pkg::REG_STEADY:   steady_needed <= cfg_data;
        default: ;
      endcase
    end
  end

  // shift-add unit: one multiplier bit per cycle
  always_ff @(posedge clk) begin
    case (state)
      alsq_pkg::ST_IDLE: begin
        acc    <= '0;
        mcand  <= alsq_pkg::ACC_W'(running ? set_lux : user_point);
        mplier <= dramatic_frac;
        step   <= '0;
      end
      alsq_pkg::ST_DRAM_MUL, alsq_pkg::ST_FILT_MUL, alsq_pkg::ST_JIT_MUL: begin
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        step   <= step + alsq_pkg::STEP_W'(1);
      end
      alsq_pkg::ST_DRAM_CMP: begin
        // filtered*2^F + half + w*(lux - filtered), modulo 2^ACC_W
        acc    <= {filtered_lux, {alsq_pkg::FRAC_W{1'b0}}} + alsq_pkg::ROUND_HALF;
        mcand  <= {{(alsq_pkg::FRAC_W-1){filt_diff[alsq_pkg::LUX_W]}}, filt_diff};
        mplier <= filter_weight;
        step   <= '0;
      end
      alsq_pkg::ST_FILT_END: begin
        acc    <= '0;
        mcand  <= alsq_pkg::ACC_W'(filt_new);
        mplier <= jitter_frac;
        step   <= '0;
      end
      default: ;
    endcase
  end

  // request state and result
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sample  <= '0;
      filtered_lux <= '0;
      set_lux      <= '0;
      steady_run   <= '0;
      dramatic_run <= '0;
      running      <= 1'b1;
      hold_active  <= 1'b0;
      held_lux     <= '0;
      user_point   <= alsq_pkg::USER_POINT_RST;
      m_tvalid     <= 1'b0;
      res_commit   <= 1'b0;
    end else begin
      case (state)
        alsq_pkg::ST_IDLE: begin
          res_commit <= 1'b0;
          res_lux    <= '0;
          lux_r      <= in_lux;
          ref_r      <= running ? set_lux : user_point;
          if (accept) begin
            case (in_req)
              alsq_pkg::REQ_SAMPLE: last_sample <= in_lux;
              alsq_pkg::REQ_OVERRIDE: begin
                hold_active <= 1'b1;
                held_lux    <= last_sample;
                running     <= 1'b0;
              end
              alsq_pkg::REQ_HOLD_END: begin
                if (hold_active) begin
                  user_point  <= held_lux & alsq_pkg::WHOLE_MASK;
                  running     <= 1'b1;
                  hold_active <= 1'b0;
                end
              end
              alsq_pkg::REQ_USER_PT: begin
                hold_active <= 1'b0;
                user_point  <= in_lux & alsq_pkg::WHOLE_MASK;
              end
              default: ;
            endcase
          end
        end
        alsq_pkg::ST_DRAM_CMP: begin
          if (!running) begin
            if (!hold_active && far) running <= 1'b1;
          end else if (far) begin
            steady_run   <= '0;
            filtered_lux <= lux_r;
            dramatic_run <= cnt_inc;
            if (cnt_inc >= steady_needed) begin
              res_commit <= 1'b1;
              res_lux    <= lux_r;
              set_lux    <= lux_r;
            end
          end else begin
            dramatic_run <= '0;
          end
        end
        alsq_pkg::ST_FILT_END: begin
          filtered_lux <= filt_new;
          ref_r        <= filt_new;
        end
        alsq_pkg::ST_JIT_CMP: begin
          if (far) begin
            steady_run <= '0;
          end else if (cnt_inc >= steady_needed) begin
            steady_run <= '0;
            res_commit <= 1'b1;
            res_lux    <= filtered_lux;
            set_lux    <= filtered_lux;
          end else begin
            steady_run <= cnt_inc;
          end
        end
        default: ;
      endcase

      if (state == alsq_pkg::ST_WB && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {{alsq_pkg::OUT_PAD{1'b0}}, running, res_lux, res_commit};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ALSQ_ASSERT_SAME(a_commit_while_auto, m_tvalid && m_tdata[0], m_tdata[alsq_pkg::LUX_W+1])
  `ALSQ_ASSERT_SAME(a_no_commit_zero_lux, m_tvalid && !m_tdata[0],
                    m_tdata[alsq_pkg::LUX_W:1] == '0)
  `ALSQ_ASSERT_SAME(a_hold_only_paused, hold_active, !running)
  `ALSQ_ASSERT_NEXT(a_accept_leaves_idle, accept, state != alsq_pkg::ST_IDLE)

endmodule
